// ----- rtl/rsm_pkg.sv -----
// ============================================================================
// rsm_pkg: shared types and constants for the RGB stream to LED string mapper
// Holds the field widths, the configuration register map and the struct
// that carries the register contents from the register file to the core.
// ============================================================================
package rsm_pkg;

    // Stream field widths.
    localparam int BYTE_W      = 8;
    localparam int STR_W       = 5;
    localparam int POS_W       = 16;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 32;
    localparam int OUT_FIELD_W = STR_W + POS_W + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Each completed color moves the channel position by three bytes.
    localparam logic [CHAN_W-1:0] CHAN_STEP = CHAN_W'(3);

    // Default and ceiling for the number of strings.
    localparam int MAX_STRINGS_DEFAULT = 16;

    // String length storage: four 64-bit registers of four 16-bit lengths.
    localparam int LEN_W        = 16;
    localparam int LEN_PER_REG  = 4;
    localparam int NUM_LEN_REGS = 4;
    localparam int NUM_LENGTHS  = LEN_PER_REG * NUM_LEN_REGS;
    localparam int LEN_IDX_W    = $clog2(NUM_LENGTHS);

    // Register port geometry: 64-bit registers at 8-byte spacing.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_LO = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_IDX_LO;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_STRINGS    = 3'd0,
        REG_FRAME_CHANNELS = 3'd1,
        REG_LEN_0_3        = 3'd2,
        REG_LEN_4_7        = 3'd3,
        REG_LEN_8_11       = 3'd4,
        REG_LEN_12_15      = 3'd5
    } cfg_reg_t;

    // Register contents as seen by the core.
    typedef struct packed {
        logic [STR_W-1:0]                        string_count;
        logic [CHAN_W-1:0]                       frame_channels;
        logic [NUM_LEN_REGS-1:0][CFG_DATA_W-1:0] length_regs;
    } cfg_t;

endpackage

// ----- rtl/rsm_cfg.sv -----
// ============================================================================
// rsm_cfg: configuration register file
// Holds the string count, the frame channel count and the string lengths.
// Written and read through a two-phase register port with no wait states.
// ============================================================================
module rsm_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rsm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rsm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rsm_pkg::cfg_t                    cfg
);

    rsm_pkg::cfg_t    cfg_reg;
    rsm_pkg::cfg_reg_t reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rsm_pkg::cfg_reg_t'(paddr[rsm_pkg::CFG_ADDR_W-1:rsm_pkg::CFG_IDX_LO]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes; addresses past the map are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rsm_pkg::REG_NUM_STRINGS:
                    cfg_reg.string_count <= pwdata[rsm_pkg::STR_W-1:0];
                rsm_pkg::REG_FRAME_CHANNELS:
                    cfg_reg.frame_channels <= pwdata[rsm_pkg::CHAN_W-1:0];
                rsm_pkg::REG_LEN_0_3:
                    cfg_reg.length_regs[0] <= pwdata;
                rsm_pkg::REG_LEN_4_7:
                    cfg_reg.length_regs[1] <= pwdata;
                rsm_pkg::REG_LEN_8_11:
                    cfg_reg.length_regs[2] <= pwdata;
                rsm_pkg::REG_LEN_12_15:
                    cfg_reg.length_regs[3] <= pwdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            rsm_pkg::REG_NUM_STRINGS:
                prdata = rsm_pkg::CFG_DATA_W'(cfg_reg.string_count);
            rsm_pkg::REG_FRAME_CHANNELS:
                prdata = rsm_pkg::CFG_DATA_W'(cfg_reg.frame_channels);
            rsm_pkg::REG_LEN_0_3:   prdata = cfg_reg.length_regs[0];
            rsm_pkg::REG_LEN_4_7:   prdata = cfg_reg.length_regs[1];
            rsm_pkg::REG_LEN_8_11:  prdata = cfg_reg.length_regs[2];
            rsm_pkg::REG_LEN_12_15: prdata = cfg_reg.length_regs[3];
            default:                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/rsm_core.sv -----
// ============================================================================
// rsm_core: byte packer, string and pixel counters and output register
// Packs three bytes into a color, tags it with string number and pixel
// position, tracks the frame boundary and holds the result for the sink.
// ============================================================================
module rsm_core
#(
    parameter int MAX_STRINGS = rsm_pkg::MAX_STRINGS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsm_pkg::cfg_t                     cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rsm_pkg::BYTE_W-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam logic [rsm_pkg::STR_W-1:0] STR_LIMIT = rsm_pkg::STR_W'(MAX_STRINGS);
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Byte phase and counters.
    logic [1:0]                  phase_reg, phase_next;
    logic [rsm_pkg::BYTE_W-1:0]  first_reg, second_reg;
    logic [rsm_pkg::STR_W-1:0]   str_reg, str_next;
    logic [rsm_pkg::POS_W-1:0]   pix_reg, pix_next;
    logic [rsm_pkg::CHAN_W-1:0]  chan_reg, chan_next;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    logic [rsm_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                              out_user_reg;
    logic                              out_last_reg;

    // Combinational result path.
    logic                                             accept;
    logic                                             emit;
    logic [rsm_pkg::STR_W-1:0]                        used;
    logic [rsm_pkg::NUM_LENGTHS-1:0][rsm_pkg::LEN_W-1:0] len_tab;
    logic [rsm_pkg::LEN_W-1:0]                        cur_len;
    logic                                             pix_ok;
    logic [rsm_pkg::POS_W-1:0]                        pix_inc;
    logic [rsm_pkg::CHAN_W-1:0]                       chan_inc;
    logic                                             frame_end;
    logic [rsm_pkg::COLOR_W-1:0]                      color;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign emit     = accept && (phase_reg != PHASE_FIRST) && (phase_reg != PHASE_SECOND);

    // String count clamp and length lookup for the current string.
    assign used    = (cfg.string_count > STR_LIMIT) ? STR_LIMIT : cfg.string_count;
    assign len_tab = cfg.length_regs;
    assign cur_len = len_tab[str_reg[rsm_pkg::LEN_IDX_W-1:0]];
    assign pix_ok  = str_reg < used;
    assign pix_inc = pix_reg + rsm_pkg::POS_W'(1);

    // Frame boundary from the advanced channel position.
    assign chan_inc  = chan_reg + rsm_pkg::CHAN_STEP;
    assign frame_end = (cfg.frame_channels != '0) && (chan_inc >= cfg.frame_channels);
    assign color     = {first_reg, second_reg, s_tdata};

    // Next state of the byte phase on every accepted byte, and of the counters on a color-completing item.
    always_comb
    begin
        phase_next = phase_reg;
        str_next   = str_reg;
        pix_next   = pix_reg;
        chan_next  = chan_reg;
        if (accept)
        begin
            case (phase_reg)
                PHASE_FIRST:  phase_next = PHASE_SECOND;
                PHASE_SECOND: phase_next = PHASE_THIRD;
                default:
                begin
                    phase_next = PHASE_FIRST;
                    pix_next   = pix_inc;
                    chan_next  = chan_inc;
                    if (pix_ok && (pix_inc >= cur_len))
                    begin
                        str_next = str_reg + rsm_pkg::STR_W'(1);
                        pix_next = '0;
                    end
                    if (frame_end)
                    begin
                        str_next  = '0;
                        pix_next  = '0;
                        chan_next = '0;
                    end
                end
            endcase
        end
    end

    // Output valid: loads on a result, drops once the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_FIRST;
            str_reg       <= '0;
            pix_reg       <= '0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            str_reg       <= str_next;
            pix_reg       <= pix_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Byte holding registers and result payload.
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PHASE_FIRST))
        begin
            first_reg <= s_tdata;
        end
        if (accept && (phase_reg == PHASE_SECOND))
        begin
            second_reg <= s_tdata;
        end
        if (emit)
        begin
            out_data_reg <= rsm_pkg::OUT_TDATA_W'({color, pix_reg, str_reg});
            out_user_reg <= pix_ok;
            out_last_reg <= frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/rgb_stream_to_led_string_mapper.sv -----
// ============================================================================
// rgb_stream_to_led_string_mapper: frame bytes to tagged LED string pixels
// Packs every three frame bytes into an RGB color and gives it with its
// string number, pixel position, valid flag and frame end mark.
// ============================================================================
//
// Channel   | Dir | Handshake               | Contents
// ----------+-----+-------------------------+----------------------------------
// s_axis    | in  | tvalid / tready         | tdata[7:0] data_byte
// m_axis    | out | tvalid / tready         | tdata string/position/color,
//           |     |                         | tuser pixel_valid, tlast frame_end
// register  | in  | psel / penable / pready | six registers at 8-byte spacing
//
// One byte is taken every cycle while input ready is high; every third byte produces a
// result in the next cycle, held in the single output register after the counter logic.
// Input ready drops only while a result is held and the sink is not ready.
// Reset clears the byte phase, all counters, the registers and the output.
// Registers are to be written only while no item is in flight.
//
module rgb_stream_to_led_string_mapper
#(
    parameter int MAX_STRINGS = rsm_pkg::MAX_STRINGS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rsm_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] data_byte
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [4:0] string_number, [20:5] pixel_position, [44:21] color, [47:45] zero
    output logic [rsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,   // [0] pixel_valid
    output logic                              m_axis_tlast,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rsm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rsm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    rsm_pkg::cfg_t cfg;

    // Register file.
    rsm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Packer, counters and output register.
    rsm_core
    #(
        .MAX_STRINGS (MAX_STRINGS)
    )
    u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // With no result held, the block always takes the next byte.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output register is empty");

    // A new result only appears right after an input byte was taken.
    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared without an accepted input item");

    // The padding bits above the packed fields stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[rsm_pkg::OUT_TDATA_W-1:rsm_pkg::OUT_FIELD_W] == '0))
        else $error("output padding bits are not zero");
`endif

endmodule

// ----- tb/sv/rgb_stream_to_led_string_mapper_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// rgb_stream_to_led_string_mapper_test: self-checking bench for the mapper
// Streams frame bytes into the mapper under several register settings. A
// scoreboard predicts every tagged pixel from the bytes taken in and compares
// the output stream against it field by field. Both stream sides idle and
// stall at random, apart from a long stretch with no idle cycles at all.
// ============================================================================
module rgb_stream_to_led_string_mapper_test;

    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 1000;

    // One predicted or observed pixel.
    typedef struct packed {
        logic                        valid;
        logic [rsm_pkg::STR_W-1:0]   string_num;
        logic [rsm_pkg::POS_W-1:0]   position;
        logic [rsm_pkg::COLOR_W-1:0] color;
        logic                        frame_end;
    } led_pixel_t;

    // Tracks the mapper's registers and counters and queues the pixels owed.
    class led_pixel_scoreboard;
        logic [rsm_pkg::STR_W-1:0]                                 strings_cfg;
        logic [rsm_pkg::CHAN_W-1:0]                                frame_len;
        logic [rsm_pkg::NUM_LEN_REGS-1:0][rsm_pkg::CFG_DATA_W-1:0] length_words;
        logic [1:0]                                                byte_slot;
        logic [rsm_pkg::BYTE_W-1:0]                                red;
        logic [rsm_pkg::BYTE_W-1:0]                                green;
        logic [rsm_pkg::STR_W-1:0]                                 string_cnt;
        logic [rsm_pkg::POS_W-1:0]                                 pixel_cnt;
        logic [rsm_pkg::CHAN_W-1:0]                                channel_pos;
        led_pixel_t                                                owed_pixels[$];
        int                                                        errors;

        function new();
            strings_cfg  = '0;
            frame_len    = '0;
            length_words = '0;
            byte_slot    = '0;
            red          = '0;
            green        = '0;
            string_cnt   = '0;
            pixel_cnt    = '0;
            channel_pos  = '0;
            errors       = 0;
        endfunction

        function void write_reg(rsm_pkg::cfg_reg_t r, logic [rsm_pkg::CFG_DATA_W-1:0] v);
            case (r)
                rsm_pkg::REG_NUM_STRINGS:    strings_cfg = v[rsm_pkg::STR_W-1:0];
                rsm_pkg::REG_FRAME_CHANNELS: frame_len = v[rsm_pkg::CHAN_W-1:0];
                rsm_pkg::REG_LEN_0_3:        length_words[0] = v;
                rsm_pkg::REG_LEN_4_7:        length_words[1] = v;
                rsm_pkg::REG_LEN_8_11:       length_words[2] = v;
                rsm_pkg::REG_LEN_12_15:      length_words[3] = v;
                default:                     ;
            endcase
        endfunction

        // Advance the prediction by one accepted byte.
        function void take_byte(logic [rsm_pkg::BYTE_W-1:0] b);
            led_pixel_t                px;
            logic [rsm_pkg::STR_W-1:0] in_use;
            logic [rsm_pkg::STR_W-1:0] ceiling;
            logic [rsm_pkg::LEN_W-1:0] len;
            ceiling = rsm_pkg::STR_W'(rsm_pkg::MAX_STRINGS_DEFAULT);
            in_use  = (strings_cfg > ceiling) ? ceiling : strings_cfg;
            if (byte_slot == 2'd0)
            begin
                red       = b;
                byte_slot = 2'd1;
                return;
            end
            if (byte_slot == 2'd1)
            begin
                green     = b;
                byte_slot = 2'd2;
                return;
            end

            px.color      = {red, green, b};
            px.valid      = (string_cnt < in_use);
            px.string_num = string_cnt;
            px.position   = pixel_cnt;

            // Move to the next string once this one is full.
            pixel_cnt = pixel_cnt + 1'b1;
            len = length_words[string_cnt[3:2]][string_cnt[1:0]*rsm_pkg::LEN_W +: rsm_pkg::LEN_W];
            if (px.valid && pixel_cnt >= len)
            begin
                string_cnt = string_cnt + 1'b1;
                pixel_cnt  = '0;
            end

            byte_slot   = 2'd0;
            channel_pos = channel_pos + rsm_pkg::CHAN_STEP;

            // Frame boundary clears every counter.
            px.frame_end = 1'b0;
            if (frame_len != 0 && channel_pos >= frame_len)
            begin
                px.frame_end = 1'b1;
                channel_pos  = '0;
                string_cnt   = '0;
                pixel_cnt    = '0;
            end
            owed_pixels.push_back(px);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        endfunction

        // Compare one output pixel with the oldest one owed.
        function void check_pixel(led_pixel_t got);
            led_pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel, expected none, got 0x%0h", $time, got);
                return;
            end
            want = owed_pixels.pop_front();
            if (got.valid !== want.valid)
                report_field("pixel_valid", want.valid, got.valid);
            if (got.string_num !== want.string_num)
                report_field("string_number", want.string_num, got.string_num);
            if (got.position !== want.position)
                report_field("pixel_position", want.position, got.position);
            if (got.color !== want.color)
                report_field("color", want.color, got.color);
            if (got.frame_end !== want.frame_end)
                report_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [rsm_pkg::BYTE_W-1:0]      s_axis_tdata;    // [7:0] data_byte
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [4:0] string_number, [20:5] pixel_position, [44:21] color, [47:45] zero
    logic [rsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;    // [0] pixel_valid
    logic                            m_axis_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rsm_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [rsm_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [rsm_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;

    led_pixel_scoreboard sb = new();
    bit                  idle_on;
    int                  quiet_cycles = 0;
    led_pixel_t          seen;

    rgb_stream_to_led_string_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // Sample both streams, randomize the sink's ready and count quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.valid      = m_axis_tuser;
                seen.string_num = m_axis_tdata[rsm_pkg::STR_W-1:0];
                seen.position   = m_axis_tdata[rsm_pkg::STR_W +: rsm_pkg::POS_W];
                seen.color      = m_axis_tdata[rsm_pkg::STR_W+rsm_pkg::POS_W +: rsm_pkg::COLOR_W];
                seen.frame_end  = m_axis_tlast;
                sb.check_pixel(seen);
            end
        end
        m_axis_tready <= !(idle_on && $urandom_range(99) < 17);

        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("rgb_stream_to_led_string_mapper verification failed");
            $finish;
        end
    end

    // One register write; psel stays up so that writes can follow back to back.
    task automatic write_reg(input rsm_pkg::cfg_reg_t r,
                             input logic [rsm_pkg::CFG_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(r, v);
    endtask

    task automatic set_config(input logic [rsm_pkg::STR_W-1:0] num,
                              input logic [rsm_pkg::CHAN_W-1:0] frame,
                              input logic [rsm_pkg::NUM_LEN_REGS-1:0][rsm_pkg::CFG_DATA_W-1:0] lens);
        write_reg(rsm_pkg::REG_NUM_STRINGS, rsm_pkg::CFG_DATA_W'(num));
        write_reg(rsm_pkg::REG_FRAME_CHANNELS, rsm_pkg::CFG_DATA_W'(frame));
        write_reg(rsm_pkg::REG_LEN_0_3, lens[0]);
        write_reg(rsm_pkg::REG_LEN_4_7, lens[1]);
        write_reg(rsm_pkg::REG_LEN_8_11, lens[2]);
        write_reg(rsm_pkg::REG_LEN_12_15, lens[3]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one byte, with an occasional gap in front, and wait for it to go in.
    task automatic send_byte(input logic [rsm_pkg::BYTE_W-1:0] b);
        if (idle_on && $urandom_range(99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 17);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Wait until every owed pixel has come out and the output register is
    // empty, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed_pixels.size() != 0 || m_axis_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [rsm_pkg::BYTE_W-1:0]                                edge_bytes[12];
        logic [rsm_pkg::NUM_LEN_REGS-1:0][rsm_pkg::CFG_DATA_W-1:0] lens;
        logic [rsm_pkg::STR_W-1:0]                                 num;
        logic [rsm_pkg::CHAN_W-1:0]                                frame;
        logic [rsm_pkg::LEN_W-1:0]                                 one_len;
        int                                                        count;

        edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
                       8'h55, 8'hAA, 8'h00, 8'hFF, 8'hFF, 8'h00};
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two strings, the first two pixels long and the second zero long, so the
        // last pixel falls beyond the configured strings.
        lens    = '0;
        lens[0] = 64'h0000_0000_0000_0002;
        set_config(5'd2, 32'd0, lens);
        foreach (edge_bytes[i])
            send_byte(edge_bytes[i]);
        drain();

        // A string count above the ceiling and a short frame.
        lens = {4{64'h0001_0001_0001_0001}};
        set_config(5'd31, 32'd6, lens);
        for (int i = 0; i < 9; i++)
            send_byte(8'($urandom));
        drain();

        // No strings in use, with neither side ever idle: every pixel is
        // invalid and the pixel counter keeps counting.
        idle_on = 1'b0;
        set_config(5'd0, 32'd0, '0);
        for (int i = 0; i < 3 * 100; i++)
            send_byte(8'($urandom));
        drain();
        idle_on = 1'b1;

        // Random settings, the register extremes among them.
        for (int k = 0; k < 10; k++)
        begin
            case (k)
                0:       num = 5'd0;
                1:       num = 5'd31;
                2:       num = 5'd16;
                default: num = 5'($urandom_range(0, 20));
            endcase
            case (k % 4)
                0:       frame = 32'd0;
                1:       frame = 32'($urandom_range(3, 240));
                2:       frame = 32'hFFFF_FFFF;
                default: frame = 32'($urandom_range(1, 60));
            endcase
            if (k == 4)
                frame = 32'($urandom);
            for (int s = 0; s < rsm_pkg::NUM_LENGTHS; s++)
            begin
                if (k == 1)
                    one_len = '0;
                else if (k == 2)
                    one_len = 16'hFFFF;
                else
                    one_len = 16'($urandom_range(0, 4));
                lens[s / rsm_pkg::LEN_PER_REG][(s % rsm_pkg::LEN_PER_REG) * rsm_pkg::LEN_W +:
                                               rsm_pkg::LEN_W] = one_len;
            end
            if (k == 5)
                lens[$urandom_range(0, 3)] = {$urandom, $urandom};
            set_config(num, frame, lens);
            // Whole colors only, so no byte group is left open across a register change.
            count = 3 * $urandom_range(30, 46);
            for (int i = 0; i < count; i++)
                send_byte(8'($urandom));
            drain();
        end

        if (sb.errors == 0 && sb.owed_pixels.size() == 0)
            $display("rgb_stream_to_led_string_mapper verification clean");
        else
            $display("rgb_stream_to_led_string_mapper verification failed");
        $finish;
    end

endmodule
